/* rtl/fthp_pkg.sv */
// Package for the five-tuple header parser.
// Holds ethertype and protocol codes, fixed header offsets and the item
// and record types shared by the parser modules. No dependencies.
`default_nettype none

package fthp_pkg;

  localparam logic [15:0] ETH_VLAN = 16'h8100;
  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;

  localparam logic [4:0] NET_START_PLAIN = 5'd14;
  localparam logic [4:0] NET_START_VLAN  = 5'd18;

  localparam logic [15:0] POS_ETYPE_LO      = 16'd13;
  localparam logic [15:0] POS_VLAN_ETYPE_LO = 16'd17;
  localparam logic [15:0] POS_MAX           = 16'hFFFF;

  localparam logic [6:0] IPV6_HDR_LEN = 7'd40;
  localparam logic [7:0] IPV4_MIN_LEN = 8'd20;
  localparam logic [7:0] IPV6_MIN_LEN = 8'd40;
  localparam logic [7:0] PORT_BYTES   = 8'd4;
  localparam logic [3:0] IHL_MIN      = 4'd5;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum logic [1:0] {
    CLASS_IPV4  = 2'd0,
    CLASS_IPV6  = 2'd1,
    CLASS_OTHER = 2'd2
  } pkt_class_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [63:0] stamp;
  } byte_item_t;

  typedef struct packed {
    pkt_class_t  pclass;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [7:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] len;
    logic [63:0] arrival;
    logic        trunc;
  } rec_t;

endpackage

`default_nettype wire

/* rtl/fthp_in_stage.sv */
// Input register of the five-tuple header parser.
// Holds one byte item and decides when it moves on; uses fthp_pkg.
`default_nettype none

module fthp_in_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               byte_valid,
  output logic                    byte_stall,
  input  wire logic [7:0]         data_byte,
  input  wire logic               last_byte,
  input  wire logic [63:0]        time_now,
  input  wire logic               rec_room,
  output fthp_pkg::byte_item_t    item,
  output logic                    advance
);

  logic held_valid;
  logic take;

  // A last byte moves on only when the result register can take its record.
  assign advance    = held_valid && (!item.last || rec_room);
  assign byte_stall = held_valid && !advance;
  assign take       = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= take || (held_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.data  <= data_byte;
      item.last  <= last_byte;
      item.stamp <= time_now;
    end
  end

endmodule

`default_nettype wire

/* rtl/fthp_parse.sv */
// Per-frame parse state of the five-tuple header parser.
// Updates offsets and captured fields for each byte and forms the record
// that the last byte of a frame produces; uses fthp_pkg.
`default_nettype none

module fthp_parse (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire fthp_pkg::byte_item_t item,
  output fthp_pkg::rec_t            rec
);

  logic [15:0]          pos, pos_next;
  logic [4:0]           ns, ns_next;
  logic [6:0]           ts, ts_next;
  fthp_pkg::pkt_class_t cls, cls_next;
  logic [7:0]           held;
  logic [7:0]           proto, proto_next;
  logic [1:0][63:0]     src, src_next;
  logic [1:0][63:0]     dst, dst_next;
  logic [1:0][15:0]     port, port_next;
  logic [63:0]          stime, stime_next;

  logic [15:0] etype;
  logic        do_class;
  logic [15:0] rel;
  logic [15:0] tdiff;
  logic        capture;
  logic [3:0]  ihl;
  logic [63:0] byte64;
  logic        l4;
  logic [7:0]  need;

  always_comb begin
    pos_next   = (pos == fthp_pkg::POS_MAX) ? pos : pos + 16'd1;
    ns_next    = ns;
    ts_next    = ts;
    cls_next   = cls;
    proto_next = proto;
    src_next   = src;
    dst_next   = dst;
    port_next  = port;
    stime_next = (pos == 16'd0) ? item.stamp : stime;
    etype      = {held, item.data};
    byte64     = {56'd0, item.data};
    ihl        = (item.data[3:0] < fthp_pkg::IHL_MIN) ? fthp_pkg::IHL_MIN : item.data[3:0];

    do_class = (pos == fthp_pkg::POS_ETYPE_LO && etype != fthp_pkg::ETH_VLAN) ||
               (pos == fthp_pkg::POS_VLAN_ETYPE_LO && ns == fthp_pkg::NET_START_VLAN);
    if (pos == fthp_pkg::POS_ETYPE_LO && etype == fthp_pkg::ETH_VLAN) begin
      ns_next = fthp_pkg::NET_START_VLAN;
    end
    if (do_class) begin
      if (etype == fthp_pkg::ETH_IPV4) begin
        cls_next = fthp_pkg::CLASS_IPV4;
      end else if (etype == fthp_pkg::ETH_IPV6) begin
        cls_next = fthp_pkg::CLASS_IPV6;
        ts_next  = {2'd0, ns} + fthp_pkg::IPV6_HDR_LEN;
      end else begin
        cls_next = fthp_pkg::CLASS_OTHER;
      end
    end

    rel     = pos - {11'd0, ns_next};
    capture = (cls_next != fthp_pkg::CLASS_OTHER) && (pos >= {11'd0, ns_next});

    if (capture) begin
      if (cls_next == fthp_pkg::CLASS_IPV4) begin
        if (rel == 16'd0) begin
          ts_next = {2'd0, ns_next} + {1'b0, ihl, 2'b00};
        end else if (rel == 16'd9) begin
          proto_next = item.data;
        end else if (rel >= 16'd12 && rel < 16'd16) begin
          src_next[1] = src_next[1] | (byte64 << {~rel[1:0], 3'b000});
        end else if (rel >= 16'd16 && rel < 16'd20) begin
          dst_next[1] = dst_next[1] | (byte64 << {~rel[1:0], 3'b000});
        end
      end else begin
        if (rel == 16'd6) begin
          proto_next = item.data;
        end else if (rel >= 16'd8 && rel < 16'd24) begin
          src_next[~rel[3]] = src_next[~rel[3]] | (byte64 << {~rel[2:0], 3'b000});
        end else if (rel >= 16'd24 && rel < 16'd40) begin
          dst_next[~rel[3]] = dst_next[~rel[3]] | (byte64 << {~rel[2:0], 3'b000});
        end
      end
    end

    tdiff = pos - {9'd0, ts_next};
    if (capture && pos >= {9'd0, ts_next} && tdiff < 16'd4) begin
      if (tdiff[0]) begin
        port_next[tdiff[1]] = port_next[tdiff[1]] | {8'd0, item.data};
      end else begin
        port_next[tdiff[1]] = port_next[tdiff[1]] | {item.data, 8'd0};
      end
    end

    l4 = (cls_next != fthp_pkg::CLASS_OTHER) &&
         (proto_next == fthp_pkg::PROTO_TCP || proto_next == fthp_pkg::PROTO_UDP);
    if (cls_next == fthp_pkg::CLASS_OTHER) begin
      need = {3'd0, ns_next};
    end else if (l4) begin
      need = {1'b0, ts_next} + fthp_pkg::PORT_BYTES;
    end else if (cls_next == fthp_pkg::CLASS_IPV4) begin
      need = {3'd0, ns_next} + fthp_pkg::IPV4_MIN_LEN;
    end else begin
      need = {3'd0, ns_next} + fthp_pkg::IPV6_MIN_LEN;
    end

    rec.pclass  = cls_next;
    rec.src_hi  = src_next[0];
    rec.src_lo  = src_next[1];
    rec.dst_hi  = dst_next[0];
    rec.dst_lo  = dst_next[1];
    rec.proto   = proto_next;
    rec.sport   = l4 ? port_next[0] : 16'd0;
    rec.dport   = l4 ? port_next[1] : 16'd0;
    rec.len     = pos_next;
    rec.arrival = stime_next;
    rec.trunc   = pos_next < {8'd0, need};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= 16'd0;
      ns    <= fthp_pkg::NET_START_PLAIN;
      ts    <= 7'd0;
      cls   <= fthp_pkg::CLASS_OTHER;
      held  <= 8'd0;
      proto <= 8'd0;
      src   <= '0;
      dst   <= '0;
      port  <= '0;
      stime <= 64'd0;
    end else if (en) begin
      stime <= stime_next;
      if (item.last) begin
        pos   <= 16'd0;
        ns    <= fthp_pkg::NET_START_PLAIN;
        ts    <= 7'd0;
        cls   <= fthp_pkg::CLASS_OTHER;
        held  <= 8'd0;
        proto <= 8'd0;
        src   <= '0;
        dst   <= '0;
        port  <= '0;
      end else begin
        pos   <= pos_next;
        ns    <= ns_next;
        ts    <= ts_next;
        cls   <= cls_next;
        held  <= item.data;
        proto <= proto_next;
        src   <= src_next;
        dst   <= dst_next;
        port  <= port_next;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/fthp_out_stage.sv */
// Result register of the five-tuple header parser.
// Holds one record until the receiver takes it; uses fthp_pkg.
`default_nettype none

module fthp_out_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire fthp_pkg::rec_t  rec_in,
  input  wire logic            rec_stall,
  output logic                 rec_valid,
  output logic                 rec_room,
  output fthp_pkg::rec_t       rec_q
);

  assign rec_room = !rec_valid || !rec_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (load) begin
      rec_valid <= 1'b1;
    end else if (!rec_stall) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_q <= rec_in;
    end
  end

endmodule

`default_nettype wire

/* rtl/five_tuple_header_parser_top.sv */
// Five-tuple header parser, top level: input register, parse state, result register.
// A record is loaded into the result register when its last byte leaves the input register.
// Throughput is one byte per cycle; only a held record on a stalled output stops a last byte.
// Reset clears the frame state, the start time and both valid flags.
// Depends on fthp_pkg, fthp_in_stage, fthp_parse and fthp_out_stage.
`default_nettype none

module five_tuple_header_parser_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic [63:0] time_now,
  output logic             rec_valid,
  input  wire logic        rec_stall,
  output logic [1:0]       packet_class,
  output logic [63:0]      src_addr_high,
  output logic [63:0]      src_addr_low,
  output logic [63:0]      dst_addr_high,
  output logic [63:0]      dst_addr_low,
  output logic [7:0]       protocol,
  output logic [15:0]      source_port,
  output logic [15:0]      dest_port,
  output logic [15:0]      packet_length,
  output logic [63:0]      arrival_time,
  output logic             truncated
);

  fthp_pkg::byte_item_t item;
  fthp_pkg::rec_t       rec_next;
  fthp_pkg::rec_t       rec_q;
  logic                 advance;
  logic                 rec_room;

  fthp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .time_now   (time_now),
    .rec_room   (rec_room),
    .item       (item),
    .advance    (advance)
  );

  fthp_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .item (item),
    .rec  (rec_next)
  );

  fthp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && item.last),
    .rec_in    (rec_next),
    .rec_stall (rec_stall),
    .rec_valid (rec_valid),
    .rec_room  (rec_room),
    .rec_q     (rec_q)
  );

  assign packet_class  = rec_q.pclass;
  assign src_addr_high = rec_q.src_hi;
  assign src_addr_low  = rec_q.src_lo;
  assign dst_addr_high = rec_q.dst_hi;
  assign dst_addr_low  = rec_q.dst_lo;
  assign protocol      = rec_q.proto;
  assign source_port   = rec_q.sport;
  assign dest_port     = rec_q.dport;
  assign packet_length = rec_q.len;
  assign arrival_time  = rec_q.arrival;
  assign truncated     = rec_q.trunc;

endmodule

`default_nettype wire

/* rtl/fthp_checker.sv */
// Port-level checks for the five-tuple header parser, bound to its top level.
// Uses only the top level's ports, the class codes and NET_START_PLAIN of fthp_pkg.
`default_nettype none

module fthp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        byte_valid,
  input wire logic        byte_stall,
  input wire logic [7:0]  data_byte,
  input wire logic        last_byte,
  input wire logic [63:0] time_now,
  input wire logic        rec_valid,
  input wire logic        rec_stall,
  input wire logic [1:0]  packet_class,
  input wire logic [63:0] src_addr_high,
  input wire logic [63:0] src_addr_low,
  input wire logic [63:0] dst_addr_high,
  input wire logic [63:0] dst_addr_low,
  input wire logic [7:0]  protocol,
  input wire logic [15:0] source_port,
  input wire logic [15:0] dest_port,
  input wire logic [15:0] packet_length,
  input wire logic [63:0] arrival_time,
  input wire logic        truncated
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !rec_valid)
    else $error("record valid after reset");

  a_hold_record: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_stall |=> rec_valid && $stable(packet_length) &&
      $stable(src_addr_low) && $stable(arrival_time))
    else $error("stalled record changed");

  a_other_empty: assert property (@(posedge clk) disable iff (rst)
    rec_valid && packet_class == fthp_pkg::CLASS_OTHER |->
      src_addr_low == 64'd0 && dst_addr_low == 64'd0 && source_port == 16'd0 &&
      protocol == 8'd0)
    else $error("other-class record carries fields");

  a_ipv4_narrow: assert property (@(posedge clk) disable iff (rst)
    rec_valid && packet_class == fthp_pkg::CLASS_IPV4 |->
      src_addr_high == 64'd0 && dst_addr_high == 64'd0 && src_addr_low[63:32] == 32'd0)
    else $error("IPv4 address outside low word");

  a_short_truncated: assert property (@(posedge clk) disable iff (rst)
    rec_valid && packet_length < {11'd0, fthp_pkg::NET_START_PLAIN} |-> truncated)
    else $error("short frame not marked truncated");

endmodule

bind five_tuple_header_parser_top fthp_checker u_fthp_checker (.*);

`default_nettype wire
